[hw/rtl/psm_pkg.sv]
`timescale 1ns / 1ps

package psm_pkg;

  // Width of an element as it arrives on the input channel.
  localparam int unsigned ValueW = 32;
  // Width of the difference target minus element, kept exact without wrap.
  localparam int unsigned WantW = ValueW + 1;
  // Width of the index fields on the result channel.
  localparam int unsigned OutIdxW = 6;

  // Result codes of one array.
  typedef enum logic [1:0] {
    STATUS_PAIR     = 2'd0,
    STATUS_NONE     = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_e;

  // Control bits that travel with one request slot down the cell chain.
  typedef struct packed {
    logic    valid;      // slot holds a request
    logic    alive;      // request still takes part in its array's search
    logic    ends;       // request carries the end mark
    logic    hit;        // a matching earlier element has been found
    logic    res_valid;  // request yields a result
    status_e status;     // result code when res_valid is set
  } slot_ctrl_t;

endpackage

[hw/rtl/pair_sum_match_search.sv]
`timescale 1ns / 1ps

// Two-sum search over arrays streamed one element per request.
// Input channel: in_valid_i / in_ready_o with element_value_i, starts_array_i
// and ends_array_i. A start mark, or any element after reset or after an end
// mark, opens a new array at index 0.
// Result channel: out_valid_o / out_ready_i with search_status_o,
// earlier_index_o and later_index_o. Each array gives exactly one result:
// a pair, no pair at its end mark, or overflow once it outgrows the store.
// The target sum is written through cfg_we_i / cfg_wdata_i; the user must
// do so only while idle, as the block does not enforce it. Throughput:
// one request per cycle while the chain is not held. Each request walks
// a chain of STORE_DEPTH cells, one per stored element. A result passes
// the entry register, which takes its request at the accepting edge,
// then a register in each cell and the output register; requests that give
// no result leave nothing. Reset clears the target, the element count and
// every slot; stored elements need no clearing. When the receiver stalls,
// the chain keeps moving until the next result reaches the last cell; only
// then do the chain and in_ready_o hold until the waiting result is taken.
module pair_sum_match_search #(
  parameter int unsigned STORE_DEPTH = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [psm_pkg::ValueW-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [psm_pkg::ValueW-1:0] element_value_i,
  input  logic                       starts_array_i,
  input  logic                       ends_array_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 search_status_o,
  output logic [psm_pkg::OutIdxW-1:0] earlier_index_o,
  output logic [psm_pkg::OutIdxW-1:0] later_index_o
);

  localparam int unsigned CntW = $clog2(STORE_DEPTH + 1);
  localparam int unsigned HitW = $clog2(STORE_DEPTH);
  localparam int unsigned NumW = $clog2(STORE_DEPTH + 2);

  logic [psm_pkg::ValueW-1:0] target_q;
  logic [NumW-1:0]            count_q, count_d;
  logic [NumW-1:0]            entry_idx;
  logic                       advance;
  logic                       accept;

  // Slot signals between the cells; index 0 is the entry register.
  psm_pkg::slot_ctrl_t        ctrl_w    [0:STORE_DEPTH];
  logic [CntW-1:0]            idx_w     [0:STORE_DEPTH];
  logic [HitW-1:0]            hit_idx_w [0:STORE_DEPTH];
  logic [psm_pkg::ValueW-1:0] value_w   [0:STORE_DEPTH];
  logic [psm_pkg::WantW-1:0]  want_w    [0:STORE_DEPTH];

  psm_pkg::slot_ctrl_t        entry_ctrl_d, entry_ctrl_q;
  logic [CntW-1:0]            entry_idx_q;
  logic [psm_pkg::ValueW-1:0] entry_value_q;
  logic [psm_pkg::WantW-1:0]  entry_want_q;

  psm_pkg::slot_ctrl_t        fin_ctrl;
  logic                       fin_overflow;
  logic                       fin_result;
  logic                       out_valid_q;
  psm_pkg::status_e           out_status_q;
  logic [psm_pkg::OutIdxW-1:0] out_early_q, out_late_q;
  logic [psm_pkg::OutIdxW-1:0] fin_early, fin_late;

  // The chain holds only when a result would meet a waiting, stalled one.
  assign fin_ctrl     = ctrl_w[STORE_DEPTH];
  assign fin_overflow = fin_ctrl.alive && !fin_ctrl.res_valid &&
                        (idx_w[STORE_DEPTH] == CntW'(STORE_DEPTH));
  assign fin_result   = fin_ctrl.valid && (fin_ctrl.res_valid || fin_overflow);
  assign advance      = !(out_valid_q && !out_ready_i && fin_result);
  assign in_ready_o   = advance;
  assign accept       = in_valid_i && advance;

  // Target register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (cfg_we_i) begin
      target_q <= cfg_wdata_i;
    end
  end

  // Element index within the array; it saturates at STORE_DEPTH + 1 so
  // that every element after an overflow is dropped at entry.
  always_comb begin
    entry_idx = starts_array_i ? '0 : count_q;
    if (ends_array_i) begin
      count_d = '0;
    end else if (entry_idx == NumW'(STORE_DEPTH + 1)) begin
      count_d = entry_idx;
    end else begin
      count_d = entry_idx + NumW'(1);
    end
    entry_ctrl_d           = '0;
    entry_ctrl_d.valid     = in_valid_i;
    entry_ctrl_d.alive     = (entry_idx <= NumW'(STORE_DEPTH));
    entry_ctrl_d.ends      = ends_array_i;
    entry_ctrl_d.hit       = 1'b0;
    entry_ctrl_d.res_valid = 1'b0;
    entry_ctrl_d.status    = psm_pkg::STATUS_NONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      entry_ctrl_q <= '0;
    end else if (advance) begin
      entry_ctrl_q <= entry_ctrl_d;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  // Entry payload, with the exact difference the earlier element must equal.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      entry_idx_q   <= entry_idx[CntW-1:0];
      entry_value_q <= element_value_i;
      entry_want_q  <= {target_q[psm_pkg::ValueW-1], target_q} -
                       {element_value_i[psm_pkg::ValueW-1], element_value_i};
    end
  end

  assign ctrl_w[0]    = entry_ctrl_q;
  assign idx_w[0]     = entry_idx_q;
  assign hit_idx_w[0] = '0;
  assign value_w[0]   = entry_value_q;
  assign want_w[0]    = entry_want_q;

  // One cell for each position of the store.
  for (genvar c = 0; c < STORE_DEPTH; c++) begin : g_cell
    psm_cell #(
      .STORE_DEPTH (STORE_DEPTH),
      .INDEX       (c)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (advance),
      .ctrl_i    (ctrl_w[c]),
      .idx_i     (idx_w[c]),
      .hit_idx_i (hit_idx_w[c]),
      .value_i   (value_w[c]),
      .want_i    (want_w[c]),
      .ctrl_o    (ctrl_w[c+1]),
      .idx_o     (idx_w[c+1]),
      .hit_idx_o (hit_idx_w[c+1]),
      .value_o   (value_w[c+1]),
      .want_o    (want_w[c+1])
    );
  end

  // Indices are reported in the low bits of the result fields.
  if (HitW >= psm_pkg::OutIdxW) begin : g_early_cut
    assign fin_early = hit_idx_w[STORE_DEPTH][psm_pkg::OutIdxW-1:0];
  end else begin : g_early_ext
    assign fin_early = {{(psm_pkg::OutIdxW-HitW){1'b0}}, hit_idx_w[STORE_DEPTH]};
  end

  if (CntW >= psm_pkg::OutIdxW) begin : g_late_cut
    assign fin_late = idx_w[STORE_DEPTH][psm_pkg::OutIdxW-1:0];
  end else begin : g_late_ext
    assign fin_late = {{(psm_pkg::OutIdxW-CntW){1'b0}}, idx_w[STORE_DEPTH]};
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!(out_valid_q && !out_ready_i)) begin
      out_valid_q <= fin_result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!(out_valid_q && !out_ready_i) && fin_result) begin
      if (fin_overflow) begin
        out_status_q <= psm_pkg::STATUS_OVERFLOW;
      end else begin
        out_status_q <= fin_ctrl.status;
      end
      if (!fin_overflow && (fin_ctrl.status == psm_pkg::STATUS_PAIR)) begin
        out_early_q <= fin_early;
        out_late_q  <= fin_late;
      end else begin
        out_early_q <= '0;
        out_late_q  <= '0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign search_status_o = out_status_q;
  assign earlier_index_o = out_early_q;
  assign later_index_o   = out_late_q;

endmodule

[hw/rtl/psm_cell.sv]
`timescale 1ns / 1ps

module psm_cell #(
  parameter int unsigned STORE_DEPTH = 64,
  parameter int unsigned INDEX       = 0
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             advance_i,
  input  psm_pkg::slot_ctrl_t              ctrl_i,
  input  logic [$clog2(STORE_DEPTH+1)-1:0] idx_i,
  input  logic [$clog2(STORE_DEPTH)-1:0]   hit_idx_i,
  input  logic [psm_pkg::ValueW-1:0]       value_i,
  input  logic [psm_pkg::WantW-1:0]        want_i,
  output psm_pkg::slot_ctrl_t              ctrl_o,
  output logic [$clog2(STORE_DEPTH+1)-1:0] idx_o,
  output logic [$clog2(STORE_DEPTH)-1:0]   hit_idx_o,
  output logic [psm_pkg::ValueW-1:0]       value_o,
  output logic [psm_pkg::WantW-1:0]        want_o
);

  localparam int unsigned CntW = $clog2(STORE_DEPTH + 1);
  localparam int unsigned HitW = $clog2(STORE_DEPTH);

  // Stored element of this position and the mark that the array closed here.
  logic [psm_pkg::ValueW-1:0] stored_q;
  logic                       closed_q;

  psm_pkg::slot_ctrl_t        ctrl_d, ctrl_q;
  logic [HitW-1:0]            hit_idx_d, hit_idx_q;
  logic [CntW-1:0]            idx_q;
  logic [psm_pkg::ValueW-1:0] value_q;
  logic [psm_pkg::WantW-1:0]  want_q;
  logic                       store_en;
  logic                       close_en;

  // An earlier position compares its element; the request's own position
  // either stores the element or closes the array on a pair.
  always_comb begin
    ctrl_d    = ctrl_i;
    hit_idx_d = hit_idx_i;
    store_en  = 1'b0;
    close_en  = 1'b0;
    if (ctrl_i.valid && ctrl_i.alive) begin
      if (idx_i > CntW'(INDEX)) begin
        if (closed_q) begin
          ctrl_d.alive = 1'b0;
        end else if ({stored_q[psm_pkg::ValueW-1], stored_q} == want_i) begin
          ctrl_d.hit = 1'b1;
          hit_idx_d  = HitW'(INDEX);
        end
      end else if (idx_i == CntW'(INDEX)) begin
        if (ctrl_i.hit) begin
          ctrl_d.res_valid = 1'b1;
          ctrl_d.status    = psm_pkg::STATUS_PAIR;
          close_en         = 1'b1;
        end else begin
          store_en = 1'b1;
          if (ctrl_i.ends) begin
            ctrl_d.res_valid = 1'b1;
            ctrl_d.status    = psm_pkg::STATUS_NONE;
          end
        end
      end
    end
  end

  // Control state of the slot and of the position.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q   <= '0;
      closed_q <= 1'b0;
    end else if (advance_i) begin
      ctrl_q <= ctrl_d;
      if (close_en) begin
        closed_q <= 1'b1;
      end else if (store_en) begin
        closed_q <= 1'b0;
      end
    end
  end

  // Payload of the slot and the stored element.
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      idx_q     <= idx_i;
      hit_idx_q <= hit_idx_d;
      value_q   <= value_i;
      want_q    <= want_i;
      if (store_en) begin
        stored_q <= value_i;
      end
    end
  end

  assign ctrl_o    = ctrl_q;
  assign idx_o     = idx_q;
  assign hit_idx_o = hit_idx_q;
  assign value_o   = value_q;
  assign want_o    = want_q;

endmodule
